// File: rtl/core/periodic_task_table_scheduler_macros.svh
// Assertion macros used by the periodic task table scheduler datapath.
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PTTS_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PTTS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/ptts_pkg.sv
// Types and constants shared by the periodic task table scheduler modules.
`default_nettype none

package ptts_pkg;

    localparam int NUM_TASKS   = 8;
    localparam int IDX_W       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] MIN_TIME_INIT = 32'h8000_0000;

    localparam int IN_DATA_W    = 112;
    localparam int OUT_FIELDS_W = 78;
    localparam int OUT_DATA_W   = 80;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_REGISTER = 3'd1,
        KIND_REMOVE   = 3'd2,
        KIND_STOP     = 3'd3,
        KIND_START    = 3'd4,
        KIND_STATUS   = 3'd5,
        KIND_REPORT   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] interval;
        logic [31:0] next_due;
        logic        active;
        logic        stopped;
        logic [31:0] min_time;
        logic [31:0] max_time;
    } t_entry;

    typedef struct packed {
        logic        ok;
        logic        due;
        logic [2:0]  slot;
        logic [7:0]  task_id;
        logic        is_active;
        logic        is_stopped;
        logic [31:0] min_time;
        logic [31:0] max_time;
        logic        last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             step;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic step_ok;
        logic fin_ok;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/periodic_task_table_scheduler.sv
// Top level of the periodic task table scheduler: controller plus datapath.
//
// Channel   Dir  tdata bits                              tuser      tlast
// s (item)  in   task_id, slot, interval, now, run_time   kind[2:0]  -
// m (res)   out  ok, slot, task_id, active, stopped,      due        last result
//                min_time, max_time
//
// Every item is accepted, then walked across the table one slot per step as the
// controller advances the slot index, and then closed out.
// The slot walk is the single read/update port of the task table.
// A result that finds the output register still full stalls the walk until the
// downstream side takes the previous transfer; the next item is accepted while a
// last result still waits in the output register.
// Reset (i_rst_n low, synchronous) clears the whole table and the global run flag.
`default_nettype none

module periodic_task_table_scheduler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Item channel.
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // tdata, low bit up: task_id[7:0], slot[10:8], interval[42:11],
    // now_ticks[74:43], run_time[106:75], zero fill.
    input  wire logic [ptts_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: kind[2:0].
    input  wire logic [2:0]                    i_s_tuser,
    // Result channel.
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // tdata, low bit up: ok[0], out_slot[3:1], out_task_id[11:4], is_active[12],
    // is_stopped[13], min_time[45:14], max_time[77:46], zero fill.
    output logic [ptts_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: due[0].
    output logic [0:0]                         o_m_tuser,
    output logic                               o_m_tlast
);
    import ptts_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller sequences accept, slot walk and finish.
    ptts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the table, applies the item to one slot per step and
    // drives the result channel from its output register.
    ptts_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/ptts_ctrl.sv
// Controller state machine: accepts an item, walks the slot index, then finishes.
`default_nettype none

module ptts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire ptts_pkg::t_stat i_stat,
    output ptts_pkg::t_cmd      o_cmd
);
    import ptts_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A slot that would produce a result waits until the holding
                // register can be drained.
                if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (i_stat.fin_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/ptts_dpath.sv
// Datapath: task table, per-slot update logic, result holding and output registers.
`default_nettype none
`include "periodic_task_table_scheduler_macros.svh"

module ptts_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ptts_pkg::t_cmd                i_cmd,
    output ptts_pkg::t_stat                    o_stat,
    input  wire logic [2:0]                    i_s_tuser,
    input  wire logic [ptts_pkg::IN_DATA_W-1:0] i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [ptts_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [0:0]                         o_m_tuser,
    output logic                               o_m_tlast
);
    import ptts_pkg::*;

    // Captured item.
    t_kind       r_kind;
    logic [7:0]  r_id;
    logic [2:0]  r_slot;
    logic [31:0] r_ivl;
    logic [31:0] r_now;
    logic [31:0] r_rt;

    t_entry      r_tab [NUM_TASKS];
    logic        r_run;
    logic        r_found;
    logic [CNT_W-1:0] r_cnt;
    logic        r_pend_valid;
    t_result     r_pend;
    logic        r_out_valid;
    t_result     r_out;

    t_entry      w_ent;
    t_entry      w_new;
    logic        w_match;
    logic        w_hit;
    logic        w_take;
    t_result     w_res;
    t_result     w_fin_res;
    logic        w_fin_emit;
    logic        w_out_room;
    logic        w_step_push;
    logic        w_fin_push;

    assign w_ent   = r_tab[i_cmd.idx];
    assign w_match = (w_ent.id == r_id);

    // Effect of the current item on the slot under the scan index.
    always_comb begin
        w_new  = w_ent;
        w_hit  = 1'b0;
        w_take = 1'b0;
        unique case (r_kind)
            KIND_TICK: begin
                if (r_run && w_ent.active && !w_ent.stopped && (w_ent.next_due <= r_now)
                        && (r_cnt < CNT_W'(MAX_RESULTS))) begin
                    w_new.next_due = r_now + w_ent.interval;
                    w_hit          = 1'b1;
                end
            end
            KIND_REGISTER: begin
                if ((r_id != 8'd0) && !r_found && !w_ent.active) begin
                    w_new.id       = r_id;
                    w_new.interval = r_ivl;
                    w_new.next_due = '0;
                    w_new.min_time = MIN_TIME_INIT;
                    w_new.max_time = '0;
                    w_new.active   = 1'b1;
                    w_new.stopped  = 1'b0;
                    w_hit          = 1'b1;
                    w_take         = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (w_match) begin
                    w_new.active = 1'b0;
                end
            end
            KIND_STOP: begin
                if ((r_id != 8'd0) && !r_found && w_match) begin
                    w_new.stopped = 1'b1;
                    w_take        = 1'b1;
                end
            end
            KIND_START: begin
                if ((r_id != 8'd0) && w_match) begin
                    w_new.stopped = 1'b0;
                end
            end
            KIND_STATUS: begin
                if ((r_id != 8'd0) && !r_found && w_match) begin
                    w_hit  = 1'b1;
                    w_take = 1'b1;
                end
            end
            KIND_REPORT: begin
                if (32'(i_cmd.idx) == 32'(r_slot)) begin
                    if (r_rt < w_ent.min_time) begin
                        w_new.min_time = r_rt;
                    end
                    if (r_rt > w_ent.max_time) begin
                        w_new.max_time = r_rt;
                    end
                end
            end
            default: begin
                w_new = w_ent;
            end
        endcase
    end

    always_comb begin
        w_res            = '0;
        w_res.ok         = (r_kind != KIND_TICK);
        w_res.due        = (r_kind == KIND_TICK);
        w_res.slot       = 3'(i_cmd.idx);
        w_res.task_id    = w_new.id;
        w_res.is_active  = w_new.active;
        w_res.is_stopped = w_new.stopped;
        w_res.min_time   = w_new.min_time;
        w_res.max_time   = w_new.max_time;
    end

    // Final result: a held result closes the run, otherwise register and status
    // answer with an empty or global result.
    always_comb begin
        w_fin_res = '0;
        if (r_pend_valid) begin
            w_fin_res = r_pend;
        end else if ((r_kind == KIND_STATUS) && (r_id == 8'd0)) begin
            w_fin_res.ok        = 1'b1;
            w_fin_res.is_active = r_run;
        end
        w_fin_res.last = 1'b1;
    end

    assign w_fin_emit  = r_pend_valid || (r_kind == KIND_REGISTER) || (r_kind == KIND_STATUS);
    assign w_out_room  = !r_out_valid || i_m_tready;
    assign w_step_push = i_cmd.step && w_hit && r_pend_valid;
    assign w_fin_push  = i_cmd.finish && w_fin_emit;

    assign o_stat.step_ok = !(w_hit && r_pend_valid) || w_out_room;
    assign o_stat.fin_ok  = !w_fin_emit || w_out_room;

    // Control state and the task table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_tab[i] <= '0;
            end
            r_run        <= 1'b0;
            r_found      <= 1'b0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_cnt   <= '0;
            end
            if (i_cmd.step) begin
                r_tab[i_cmd.idx] <= w_new;
                r_found          <= r_found | w_take;
                if (w_hit) begin
                    r_pend_valid <= 1'b1;
                    r_cnt        <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
                if ((r_kind == KIND_STOP) && (r_id == 8'd0)) begin
                    r_run <= 1'b0;
                end else if ((r_kind == KIND_START) && (r_id == 8'd0)) begin
                    r_run <= 1'b1;
                end
            end
            if (w_step_push || w_fin_push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_kind'(i_s_tuser);
            r_id   <= i_s_tdata[7:0];
            r_slot <= i_s_tdata[10:8];
            r_ivl  <= i_s_tdata[42:11];
            r_now  <= i_s_tdata[74:43];
            r_rt   <= i_s_tdata[106:75];
        end
        if (i_cmd.step && w_hit) begin
            r_pend <= w_res;
        end
        if (w_step_push) begin
            r_out <= r_pend;
        end else if (w_fin_push) begin
            r_out <= w_fin_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tuser  = r_out.due;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                         r_out.max_time, r_out.min_time, r_out.is_stopped, r_out.is_active,
                         r_out.task_id, r_out.slot, r_out.ok};

    `PTTS_ASSERT_NEVER(a_load_with_pending, i_cmd.load && r_pend_valid, "held result at item load")
    `PTTS_ASSERT_NEVER(a_push_overwrites, w_step_push && r_out_valid && !i_m_tready, "output overwritten")
    `PTTS_ASSERT_HOLDS(a_tick_count_cap, r_cnt <= CNT_W'(MAX_RESULTS), "too many tick results")

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the periodic task table scheduler stream block.
`timescale 1ns / 100ps

// Mirror of the task table. It predicts the results of every accepted item
// and holds them in order until the result channel delivers them.
class task_table_scoreboard;

    logic [7:0]  slot_id       [ptts_pkg::NUM_TASKS];
    logic [31:0] slot_interval [ptts_pkg::NUM_TASKS];
    logic [31:0] slot_next_due [ptts_pkg::NUM_TASKS];
    logic        slot_active   [ptts_pkg::NUM_TASKS];
    logic        slot_stopped  [ptts_pkg::NUM_TASKS];
    logic [31:0] slot_min_time [ptts_pkg::NUM_TASKS];
    logic [31:0] slot_max_time [ptts_pkg::NUM_TASKS];
    logic        sched_running;

    ptts_pkg::t_result pending_replies[$];
    int error_count;

    function new();
        for (int s = 0; s < ptts_pkg::NUM_TASKS; s++) begin
            slot_id[s]       = '0;
            slot_interval[s] = '0;
            slot_next_due[s] = '0;
            slot_active[s]   = 1'b0;
            slot_stopped[s]  = 1'b0;
            slot_min_time[s] = '0;
            slot_max_time[s] = '0;
        end
        sched_running = 1'b0;
        error_count   = 0;
    endfunction

    function ptts_pkg::t_result slot_reply(int s, logic ok, logic due);
        ptts_pkg::t_result r;
        r            = '0;
        r.ok         = ok;
        r.due        = due;
        r.slot       = s[2:0];
        r.task_id    = slot_id[s];
        r.is_active  = slot_active[s];
        r.is_stopped = slot_stopped[s];
        r.min_time   = slot_min_time[s];
        r.max_time   = slot_max_time[s];
        return r;
    endfunction

    // Updates the table for one accepted item and queues its results.
    function void accept_item(logic [2:0] kind, logic [7:0] id, logic [2:0] slot,
                              logic [31:0] ivl, logic [31:0] now, logic [31:0] rt);
        ptts_pkg::t_result r;
        ptts_pkg::t_result runs[$];
        r = '0;
        case (kind)
            ptts_pkg::KIND_TICK: begin
                if (sched_running) begin
                    for (int s = 0; s < ptts_pkg::NUM_TASKS; s++) begin
                        if (runs.size() < ptts_pkg::MAX_RESULTS && slot_active[s] &&
                            !slot_stopped[s] && slot_next_due[s] <= now) begin
                            slot_next_due[s] = now + slot_interval[s];
                            runs.push_back(slot_reply(s, 1'b0, 1'b1));
                        end
                    end
                    if (runs.size() > 0) runs[runs.size() - 1].last = 1'b1;
                    foreach (runs[k]) pending_replies.push_back(runs[k]);
                end
            end
            ptts_pkg::KIND_REGISTER: begin
                if (id != 8'd0) begin
                    for (int s = 0; s < ptts_pkg::NUM_TASKS; s++) begin
                        if (!slot_active[s]) begin
                            slot_id[s]       = id;
                            slot_interval[s] = ivl;
                            slot_next_due[s] = '0;
                            slot_min_time[s] = ptts_pkg::MIN_TIME_INIT;
                            slot_max_time[s] = '0;
                            slot_active[s]   = 1'b1;
                            slot_stopped[s]  = 1'b0;
                            r = slot_reply(s, 1'b1, 1'b0);
                            break;
                        end
                    end
                end
                r.last = 1'b1;
                pending_replies.push_back(r);
            end
            ptts_pkg::KIND_REMOVE: begin
                for (int s = 0; s < ptts_pkg::NUM_TASKS; s++)
                    if (slot_id[s] == id) slot_active[s] = 1'b0;
            end
            ptts_pkg::KIND_STOP: begin
                if (id == 8'd0) begin
                    sched_running = 1'b0;
                end else begin
                    for (int s = 0; s < ptts_pkg::NUM_TASKS; s++) begin
                        if (slot_id[s] == id) begin
                            slot_stopped[s] = 1'b1;
                            break;
                        end
                    end
                end
            end
            ptts_pkg::KIND_START: begin
                if (id == 8'd0) begin
                    sched_running = 1'b1;
                end else begin
                    for (int s = 0; s < ptts_pkg::NUM_TASKS; s++)
                        if (slot_id[s] == id) slot_stopped[s] = 1'b0;
                end
            end
            ptts_pkg::KIND_STATUS: begin
                if (id == 8'd0) begin
                    r.ok        = 1'b1;
                    r.is_active = sched_running;
                end else begin
                    for (int s = 0; s < ptts_pkg::NUM_TASKS; s++) begin
                        if (slot_id[s] == id) begin
                            r = slot_reply(s, 1'b1, 1'b0);
                            break;
                        end
                    end
                end
                r.last = 1'b1;
                pending_replies.push_back(r);
            end
            ptts_pkg::KIND_REPORT: begin
                if (slot < ptts_pkg::NUM_TASKS) begin
                    if (rt < slot_min_time[slot]) slot_min_time[slot] = rt;
                    if (rt > slot_max_time[slot]) slot_max_time[slot] = rt;
                end
            end
            default: ;
        endcase
    endfunction

    function void flag_field(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= 10)
            $display("MISMATCH %s: expected %0h, got %0h", field, want, got);
    endfunction

    // Compares one delivered result with the oldest pending one.
    function void check_reply(ptts_pkg::t_result got);
        ptts_pkg::t_result want;
        if (pending_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
                $display("MISMATCH unexpected result: slot %0d id %0h due %0b",
                         got.slot, got.task_id, got.due);
            return;
        end
        want = pending_replies.pop_front();
        if (got.ok !== want.ok)                 flag_field("ok", want.ok, got.ok);
        if (got.due !== want.due)               flag_field("due", want.due, got.due);
        if (got.slot !== want.slot)             flag_field("out_slot", want.slot, got.slot);
        if (got.task_id !== want.task_id)       flag_field("out_task_id", want.task_id,
                                                           got.task_id);
        if (got.is_active !== want.is_active)   flag_field("is_active", want.is_active,
                                                           got.is_active);
        if (got.is_stopped !== want.is_stopped) flag_field("is_stopped", want.is_stopped,
                                                           got.is_stopped);
        if (got.min_time !== want.min_time)     flag_field("min_time", want.min_time,
                                                           got.min_time);
        if (got.max_time !== want.max_time)     flag_field("max_time", want.max_time,
                                                           got.max_time);
        if (got.last !== want.last)             flag_field("last", want.last, got.last);
    endfunction

endclass

module testbench;

    // The unused command code; the block must swallow it without a result.
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 440;
    localparam int CALM_ITEMS   = 60;     // final stretch without any idling
    localparam int PRESSURE_AT  = 150;    // random item index that starts the long hold
    localparam int LONG_HOLD    = 400;    // cycles the receiver refuses transfers
    localparam int DRAIN_CYCLES = 2 * (ptts_pkg::NUM_TASKS + 2);
    localparam int CYCLE_LIMIT  = 400000;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    // task_id, slot, interval, now_ticks, run_time, zero fill (lowest bit up).
    logic [ptts_pkg::IN_DATA_W-1:0]    i_s_tdata;
    // kind.
    logic [2:0]                        i_s_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    // ok, out_slot, out_task_id, is_active, is_stopped, min_time, max_time, zero fill.
    logic [ptts_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    // due.
    logic [0:0]                        o_m_tuser;
    logic                              o_m_tlast;

    task_table_scoreboard table_sb = new();

    // Shared controls between the stimulus thread and the receiver thread.
    bit calm;
    bit hold_req;

    // Running tick count offered by tick items; mostly creeps forward.
    logic [31:0] tick_now;

    periodic_task_table_scheduler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offers one item and returns at the rising edge where the transfer
    // happens. It is always entered right after a rising edge, so each call
    // makes at most one assignment to the valid line in that time step.
    task automatic send_item(input logic [2:0] kind, input logic [7:0] id,
                             input logic [2:0] slot, input logic [31:0] ivl,
                             input logic [31:0] now, input logic [31:0] rt);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {5'b0, rt, now, ivl, slot, id};
        do @(posedge i_clk); while (!o_s_tready);
        table_sb.accept_item(kind, id, slot, ivl, now, rt);
    endtask

    // Directed opening: global flag handling, a full table, the rejected id,
    // duplicate ids, time wraparound, report extremes and the unused code.
    task automatic run_directed();
        logic [7:0]  reg_ids [8] = '{8'd1, 8'd255, 8'd7, 8'd7, 8'd128, 8'd3, 8'd85, 8'd170};
        logic [31:0] reg_ivls[8] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd5,
                                     32'h8000_0000, 32'd2, 32'd3, 32'd10};
        // Scheduler still stopped: status reports it, a tick is silent.
        send_item(ptts_pkg::KIND_STATUS, 8'd0, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_TICK, 8'd0, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(ptts_pkg::KIND_REGISTER, 8'd0, 3'd0, 32'd4, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_REMOVE, 8'd0, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(KIND_UNUSED, 8'd255, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (reg_ids[k])
            send_item(ptts_pkg::KIND_REGISTER, reg_ids[k], 3'd0, reg_ivls[k], 32'd0, 32'd0);
        // Table is full now, so this one must fail.
        send_item(ptts_pkg::KIND_REGISTER, 8'd9, 3'd0, 32'd1, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_START, 8'd0, 3'd0, 32'd0, 32'd0, 32'd0);
        // Every slot is due at tick zero, then again at the top of the range,
        // where now plus interval wraps.
        send_item(ptts_pkg::KIND_TICK, 8'd0, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_TICK, 8'd0, 3'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        // Stop hits only the first slot holding id 7.
        send_item(ptts_pkg::KIND_STOP, 8'd7, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_TICK, 8'd0, 3'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(ptts_pkg::KIND_REPORT, 8'd0, 3'd7, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_REPORT, 8'd0, 3'd7, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(ptts_pkg::KIND_STATUS, 8'd7, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_START, 8'd7, 3'd0, 32'd0, 32'd0, 32'd0);
        // Remove drops both copies of id 7; the slot keeps the id for status.
        send_item(ptts_pkg::KIND_REMOVE, 8'd7, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_STATUS, 8'd7, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_REPORT, 8'd0, 3'd2, 32'd0, 32'd0, 32'd12);
        send_item(ptts_pkg::KIND_STOP, 8'd0, 3'd0, 32'd0, 32'd0, 32'd0);
        send_item(ptts_pkg::KIND_STATUS, 8'd0, 3'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // Random traffic. Ids come mostly from a small pool so that commands
    // actually find their tasks; ticks mostly advance slowly so that tasks
    // fall due at varied times, with occasional jumps across the whole range.
    task automatic run_random();
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [2:0]  slot;
        logic [31:0] ivl;
        logic [31:0] now;
        logic [31:0] rt;
        int          pick;
        tick_now = 32'd0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;

            id   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(1, 10));
            slot = 3'($urandom_range(0, 7));
            ivl  = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 15));
            pick = $urandom_range(0, 19);
            if (pick == 0)      tick_now = 32'($urandom);
            else if (pick == 1) tick_now = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
            else                tick_now = tick_now + 32'($urandom_range(0, 12));
            now  = tick_now;
            pick = $urandom_range(0, 9);
            if (pick == 0)      rt = 32'($urandom);
            else if (pick == 1) rt = 32'hFFFF_FFFF;
            else if (pick == 2) rt = 32'd0;
            else                rt = 32'($urandom_range(0, 1000));

            pick = $urandom_range(0, 99);
            if (pick < 34) begin
                kind = ptts_pkg::KIND_TICK;
            end else if (pick < 46) begin
                kind = ptts_pkg::KIND_REGISTER;
            end else if (pick < 54) begin
                kind = ptts_pkg::KIND_REMOVE;
            end else if (pick < 62) begin
                kind = ptts_pkg::KIND_STOP;
                if ($urandom_range(0, 6) == 0) id = 8'd0;
            end else if (pick < 72) begin
                kind = ptts_pkg::KIND_START;
                if ($urandom_range(0, 2) == 0) id = 8'd0;
            end else if (pick < 84) begin
                kind = ptts_pkg::KIND_STATUS;
                if ($urandom_range(0, 7) == 0) id = 8'd0;
            end else if (pick < 97) begin
                kind = ptts_pkg::KIND_REPORT;
            end else begin
                kind = KIND_UNUSED;
            end

            // Long receiver hold: make sure the scheduler runs, then let the
            // sender keep offering items while the output side is blocked.
            if (n == PRESSURE_AT) begin
                send_item(ptts_pkg::KIND_START, 8'd0, slot, ivl, now, rt);
                hold_req = 1'b1;
            end
            send_item(kind, id, slot, ivl, now, rt);
        end
    endtask

    // Receiver: ready in stretches, short refusals in random bursts, and one
    // long refusal on request. One assignment per loop pass, then at least
    // one clock edge, so the ready line never gets two updates in one step.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Result monitor: a transfer is taken at the edge where valid and ready
    // were both high; the values read here are the ones the edge sampled.
    always @(posedge i_clk) begin
        ptts_pkg::t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.ok         = o_m_tdata[0];
            got.slot       = o_m_tdata[3:1];
            got.task_id    = o_m_tdata[11:4];
            got.is_active  = o_m_tdata[12];
            got.is_stopped = o_m_tdata[13];
            got.min_time   = o_m_tdata[45:14];
            got.max_time   = o_m_tdata[77:46];
            got.due        = o_m_tuser[0];
            got.last       = o_m_tlast;
            table_sb.check_reply(got);
        end
    end

    // Watchdog: a run that has not ended by the limit has hung.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("periodic_task_table_scheduler verification failed");
        $finish;
    end

    // Main sequence: reset, directed items, random items, then drain.
    initial begin
        calm     = 1'b0;
        hold_req = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();
        i_s_tvalid <= 1'b0;

        while (table_sb.pending_replies.size() != 0) @(posedge i_clk);
        // Items without results may still be walking the table.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (table_sb.error_count == 0 && table_sb.pending_replies.size() == 0) begin
            $display("periodic_task_table_scheduler verification clean");
        end else begin
            $display("periodic_task_table_scheduler verification failed");
        end
        $finish;
    end

endmodule
